>>> rtl/fsam_pkg.sv
`default_nettype none

package fsam_pkg;

    // Fixed field widths
    localparam int FRAC_BITS      = 16;
    localparam int COORD_BITS_DEF = 12;
    localparam int ALPHA_W        = 8;
    localparam int FACTOR_W       = 17;
    localparam int GEOM_W         = 18;
    localparam int FEATHER_W      = 20;
    localparam int CFG_DATA_W     = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int OUT_TDATA_W    = ((ALPHA_W + FACTOR_W + 7) / 8) * 8;

    // Final divisor width: linear feather scaled by 2^14
    localparam int DIVF_W         = FEATHER_W + 14;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;

    // Mask modes
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_RECT    = 2'd1;
    localparam logic [1:0] MODE_ELLIPSE = 2'd2;
    localparam logic [1:0] MODE_LINEAR  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM_C  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM_D  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FEATHER = 3'd6;

    // Reset value and lower bounds on geometry
    localparam logic [FEATHER_W-1:0]     FEATHER_RST     = 20'd16;
    localparam logic [FEATHER_W-1:0]     FEATHER_MIN     = 20'd16;
    localparam logic [FEATHER_W-1:0]     FEATHER_MIN_ELL = 20'd66;
    localparam logic signed [GEOM_W-1:0] RADIUS_MIN      = 18'sd16;

    // Pipeline control handed to the arithmetic units
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

`default_nettype wire

>>> rtl/fsam_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Needs i_num < i_den * 2^QUO_W; divisor is held steady by the caller.
module fsam_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17,
    parameter int QUO_W = 30,
    parameter int SB_W  = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fsam_pkg::t_pipe_ctl i_ctl,
    input  wire logic [NUM_W-1:0]    i_num,
    input  wire logic [DEN_W-1:0]    i_den,
    input  wire logic [SB_W-1:0]     i_sb,
    output logic                     o_valid,
    output logic [QUO_W-1:0]         o_quo,
    output logic [SB_W-1:0]          o_sb
);

    logic [DEN_W-1:0] r_rem [0:QUO_W-1];
    logic [QUO_W-1:0] r_low [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo [0:QUO_W-1];
    logic [SB_W-1:0]  r_sb  [0:QUO_W-1];
    logic [QUO_W-1:0] r_v;

    for (genvar gi = 0; gi < QUO_W; gi++) begin : g_stage
        logic [DEN_W-1:0] cur_rem;
        logic [QUO_W-1:0] cur_low;
        logic [QUO_W-1:0] cur_quo;
        logic [SB_W-1:0]  cur_sb;
        logic             cur_v;
        logic [DEN_W:0]   trial;
        logic             fits;

        if (gi == 0) begin : g_first
            // high numerator bits are already below the divisor
            assign cur_rem = DEN_W'(i_num[NUM_W-1:QUO_W]);
            assign cur_low = i_num[QUO_W-1:0];
            assign cur_quo = '0;
            assign cur_sb  = i_sb;
            assign cur_v   = i_ctl.valid;
        end else begin : g_next
            assign cur_rem = r_rem[gi-1];
            assign cur_low = r_low[gi-1];
            assign cur_quo = r_quo[gi-1];
            assign cur_sb  = r_sb[gi-1];
            assign cur_v   = r_v[gi-1];
        end

        // trial subtract of the shifted remainder
        assign trial = {cur_rem, cur_low[QUO_W-1]};
        assign fits  = trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[gi] <= fits ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);
                r_low[gi] <= cur_low << 1;
                r_quo[gi] <= {cur_quo[QUO_W-2:0], fits};
                r_sb[gi]  <= cur_sb;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[gi] <= cur_v;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_sb    = r_sb[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/fsam_isqrt.sv
`default_nettype none

// Pipelined integer square root (floor), one root bit per stage.
module fsam_isqrt #(
    parameter int RAD_W = 66,
    parameter int SB_W  = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fsam_pkg::t_pipe_ctl i_ctl,
    input  wire logic [RAD_W-1:0]    i_rad,
    input  wire logic [SB_W-1:0]     i_sb,
    output logic                     o_valid,
    output logic [RAD_W/2-1:0]       o_root,
    output logic [SB_W-1:0]          o_sb
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [RAD_W-1:0]  r_low  [0:ROOT_W-1];
    logic [SB_W-1:0]   r_sb   [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_v;

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_stage
        logic [REM_W-1:0]  cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [RAD_W-1:0]  cur_low;
        logic [SB_W-1:0]   cur_sb;
        logic              cur_v;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  cand;
        logic              fits;

        if (gi == 0) begin : g_first
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_low  = i_rad;
            assign cur_sb   = i_sb;
            assign cur_v    = i_ctl.valid;
        end else begin : g_next
            assign cur_rem  = r_rem[gi-1];
            assign cur_root = r_root[gi-1];
            assign cur_low  = r_low[gi-1];
            assign cur_sb   = r_sb[gi-1];
            assign cur_v    = r_v[gi-1];
        end

        // bring down the next bit pair, try root*4+1
        assign trial = {cur_rem[REM_W-3:0], cur_low[RAD_W-1:RAD_W-2]};
        assign cand  = {cur_root, 2'b01};
        assign fits  = trial >= cand;

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[gi]  <= fits ? (trial - cand) : trial;
                r_root[gi] <= {cur_root[ROOT_W-2:0], fits};
                r_low[gi]  <= cur_low << 2;
                r_sb[gi]   <= cur_sb;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[gi] <= cur_v;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_sb    = r_sb[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/feathered_shape_alpha_mask_core.sv
// Throughput: one item per cycle while the skid register is empty; that register
// holds one result under back-pressure, and input is not taken while it is full.
// Reset: synchronous active-low i_rst_n clears valid bits, skid and registers to
// mode none, no invert, zero geometry and a feather of 16.
`default_nettype none

module feathered_shape_alpha_mask_core #(
    parameter int COORD_BITS = fsam_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [pixel_x, pixel_y, alpha_in] from bit 0 up, zero padded to bytes
    input  wire logic [((2*COORD_BITS+fsam_pkg::ALPHA_W+7)/8)*8-1:0] s_axis_tdata,
    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [alpha_out, mask_factor] from bit 0 up, zero padded to bytes
    output logic [fsam_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // register writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [fsam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fsam_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import fsam_pkg::*;

    localparam int XW    = COORD_BITS + 4;             // Q.4 coordinate
    localparam int SW    = ((XW > 19) ? XW : 19) + 2;  // signed differences
    localparam int MW    = SW - 1;                     // magnitudes
    localparam int PW    = SW + GEOM_W;                // linear products
    localparam int LW    = PW + 1;                     // linear projection
    localparam int NXW   = MW + 12;                    // normalised radius terms
    localparam int RQ    = NXW + 1;                    // root width
    localparam int RAD_W = 2 * RQ;
    localparam int VW    = 2 * MW + 1 + FRAC_BITS;     // rect radicand
    localparam int RX_W  = GEOM_W - 1;
    localparam int DSB_W = 2 + VW;
    localparam int ISB_W = ALPHA_W + 2 + DIVF_W;
    localparam int FSB_W = ALPHA_W + 2;

    // ---------------- configuration registers ----------------
    logic [1:0]                r_mode;
    logic                      r_invert;
    logic signed [GEOM_W-1:0]  r_geom_a;
    logic signed [GEOM_W-1:0]  r_geom_b;
    logic signed [GEOM_W-1:0]  r_geom_c;
    logic signed [GEOM_W-1:0]  r_geom_d;
    logic [FEATHER_W-1:0]      r_feather;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NONE;
            r_invert  <= 1'b0;
            r_geom_a  <= '0;
            r_geom_b  <= '0;
            r_geom_c  <= '0;
            r_geom_d  <= '0;
            r_feather <= FEATHER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:    r_mode    <= i_cfg_data[1:0];
                REG_INVERT:  r_invert  <= i_cfg_data[0];
                REG_GEOM_A:  r_geom_a  <= $signed(i_cfg_data[GEOM_W-1:0]);
                REG_GEOM_B:  r_geom_b  <= $signed(i_cfg_data[GEOM_W-1:0]);
                REG_GEOM_C:  r_geom_c  <= $signed(i_cfg_data[GEOM_W-1:0]);
                REG_GEOM_D:  r_geom_d  <= $signed(i_cfg_data[GEOM_W-1:0]);
                REG_FEATHER: r_feather <= i_cfg_data[FEATHER_W-1:0];
                default: ;
            endcase
        end
    end

    // Derived geometry, unchecked; user must keep it constant while items are in flight
    logic signed [GEOM_W:0]   a_plus_c;
    logic signed [GEOM_W:0]   b_plus_d;
    logic [RX_W-1:0]          rx;
    logic [RX_W-1:0]          ry;
    logic [FEATHER_W-1:0]     fe_lin;
    logic [FEATHER_W-1:0]     fe_ell;
    logic [DIVF_W-1:0]        f_rect;
    logic [DIVF_W-1:0]        f_lin;
    logic [DIVF_W-1:0]        f_ell;
    logic [DIVF_W-1:0]        f_div;

    assign a_plus_c = (GEOM_W+1)'(r_geom_a) + (GEOM_W+1)'(r_geom_c);
    assign b_plus_d = (GEOM_W+1)'(r_geom_b) + (GEOM_W+1)'(r_geom_d);
    assign rx     = (r_geom_c < RADIUS_MIN) ? RX_W'(RADIUS_MIN) : r_geom_c[RX_W-1:0];
    assign ry     = (r_geom_d < RADIUS_MIN) ? RX_W'(RADIUS_MIN) : r_geom_d[RX_W-1:0];
    assign fe_lin = (r_feather < FEATHER_MIN) ? FEATHER_MIN : r_feather;
    assign fe_ell = (r_feather < FEATHER_MIN_ELL) ? FEATHER_MIN_ELL : r_feather;
    assign f_rect = DIVF_W'({fe_lin, 8'b0});
    assign f_lin  = {fe_lin, 14'b0};
    assign f_ell  = DIVF_W'(fe_ell);

    always_comb begin
        case (r_mode)
            MODE_RECT:    f_div = f_rect;
            MODE_ELLIPSE: f_div = f_ell;
            default:      f_div = f_lin;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic pipe_en;
    logic r_skid_v;

    assign pipe_en       = !r_skid_v;
    assign s_axis_tready = pipe_en;

    // ---------------- stage 1: offsets from the shape ----------------
    logic [XW-1:0]           in_x;
    logic [XW-1:0]           in_y;
    logic signed [SW-1:0]    x_s;
    logic signed [SW-1:0]    y_s;
    logic                    r1_v;
    logic signed [SW-1:0]    r1_dxa;
    logic signed [SW-1:0]    r1_dya;
    logic signed [SW-1:0]    r1_dxh;
    logic signed [SW-1:0]    r1_dyh;
    logic [ALPHA_W-1:0]      r1_alpha;

    assign in_x = {s_axis_tdata[COORD_BITS-1:0], 4'b0};
    assign in_y = {s_axis_tdata[2*COORD_BITS-1:COORD_BITS], 4'b0};
    assign x_s  = $signed(SW'(in_x));
    assign y_s  = $signed(SW'(in_y));

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_dxa   <= x_s - SW'(r_geom_a);
            r1_dya   <= y_s - SW'(r_geom_b);
            r1_dxh   <= x_s - SW'(a_plus_c);
            r1_dyh   <= y_s - SW'(b_plus_d);
            r1_alpha <= s_axis_tdata[2*COORD_BITS+ALPHA_W-1:2*COORD_BITS];
        end
    end

    // ---------------- stage 2: gaps, magnitudes, projections ----------------
    logic [MW-1:0]           gap_x;
    logic [MW-1:0]           gap_y;
    logic [MW-1:0]           abs_x;
    logic [MW-1:0]           abs_y;
    logic                    r2_v;
    logic [MW-1:0]           r2_mx;
    logic [MW-1:0]           r2_my;
    logic signed [PW-1:0]    r2_pc;
    logic signed [PW-1:0]    r2_ps;
    logic [ALPHA_W-1:0]      r2_alpha;

    always_comb begin
        gap_x = '0;
        if (r1_dxa < 0) begin
            gap_x = MW'(-r1_dxa);
        end else if (r1_dxh > 0) begin
            gap_x = MW'(r1_dxh);
        end
        gap_y = '0;
        if (r1_dya < 0) begin
            gap_y = MW'(-r1_dya);
        end else if (r1_dyh > 0) begin
            gap_y = MW'(r1_dyh);
        end
        abs_x = (r1_dxa < 0) ? MW'(-r1_dxa) : MW'(r1_dxa);
        abs_y = (r1_dya < 0) ? MW'(-r1_dya) : MW'(r1_dya);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_mx    <= (r_mode == MODE_ELLIPSE) ? abs_x : gap_x;
            r2_my    <= (r_mode == MODE_ELLIPSE) ? abs_y : gap_y;
            r2_pc    <= PW'(r1_dxa) * PW'(r_geom_c);
            r2_ps    <= PW'(r1_dya) * PW'(r_geom_d);
            r2_alpha <= r1_alpha;
        end
    end

    // ---------------- stage 3: squares and projection sum ----------------
    logic                    r3_v;
    logic [2*MW-1:0]         r3_sqx;
    logic [2*MW-1:0]         r3_sqy;
    logic signed [LW-1:0]    r3_p;
    logic [MW-1:0]           r3_mx;
    logic [MW-1:0]           r3_my;
    logic [ALPHA_W-1:0]      r3_alpha;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_sqx   <= (2*MW)'(r2_mx) * (2*MW)'(r2_mx);
            r3_sqy   <= (2*MW)'(r2_my) * (2*MW)'(r2_my);
            r3_p     <= LW'(r2_pc) + LW'(r2_ps);
            r3_mx    <= r2_mx;
            r3_my    <= r2_my;
            r3_alpha <= r2_alpha;
        end
    end

    // ---------------- stage 4: rect radicand, linear decision ----------------
    logic [2*MW:0]           sum_sq;
    logic                    lin_neg;
    logic                    lin_over;
    logic                    r4_v;
    logic [VW-1:0]           r4_val;
    logic                    r4_lone;
    logic                    r4_lzero;
    logic [MW-1:0]           r4_mx;
    logic [MW-1:0]           r4_my;
    logic [ALPHA_W-1:0]      r4_alpha;

    assign sum_sq   = {1'b0, r3_sqx} + {1'b0, r3_sqy};
    assign lin_neg  = r3_p < 0;
    assign lin_over = !lin_neg && (r3_p > $signed(LW'(f_lin)));

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (r_mode == MODE_LINEAR) begin
                r4_val <= (lin_neg || lin_over) ? '0 : VW'(r3_p[DIVF_W-1:0]);
            end else begin
                r4_val <= {sum_sq, {FRAC_BITS{1'b0}}};
            end
            r4_lone  <= lin_neg;
            r4_lzero <= lin_over;
            r4_mx    <= r3_mx;
            r4_my    <= r3_my;
            r4_alpha <= r3_alpha;
        end
    end

    // ---------------- ellipse normalisation dividers ----------------
    t_pipe_ctl               dn_ctl;
    logic                    dn_v;
    logic [NXW-1:0]          nx;
    logic [NXW-1:0]          ny;
    logic [DSB_W-1:0]        dnx_sb;
    logic [ALPHA_W-1:0]      dny_alpha;

    assign dn_ctl.en    = pipe_en;
    assign dn_ctl.valid = r4_v;

    fsam_div #(
        .NUM_W (MW + FRAC_BITS),
        .DEN_W (RX_W),
        .QUO_W (NXW),
        .SB_W  (DSB_W)
    ) u_div_nx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dn_ctl),
        .i_num   ({r4_mx, {FRAC_BITS{1'b0}}}),
        .i_den   (rx),
        .i_sb    ({r4_lone, r4_lzero, r4_val}),
        .o_valid (dn_v),
        .o_quo   (nx),
        .o_sb    (dnx_sb)
    );

    fsam_div #(
        .NUM_W (MW + FRAC_BITS),
        .DEN_W (RX_W),
        .QUO_W (NXW),
        .SB_W  (ALPHA_W)
    ) u_div_ny (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dn_ctl),
        .i_num   ({r4_my, {FRAC_BITS{1'b0}}}),
        .i_den   (ry),
        .i_sb    (r4_alpha),
        .o_valid (),
        .o_quo   (ny),
        .o_sb    (dny_alpha)
    );

    // ---------------- stage 5: squares of normalised terms ----------------
    logic                    r5_v;
    logic [2*NXW-1:0]        r5_nx2;
    logic [2*NXW-1:0]        r5_ny2;
    logic [DSB_W-1:0]        r5_sb;
    logic [ALPHA_W-1:0]      r5_alpha;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_nx2   <= (2*NXW)'(nx) * (2*NXW)'(nx);
            r5_ny2   <= (2*NXW)'(ny) * (2*NXW)'(ny);
            r5_sb    <= dnx_sb;
            r5_alpha <= dny_alpha;
        end
    end

    // ---------------- stage 6: radicand select ----------------
    logic                    r6_v;
    logic [RAD_W-1:0]        r6_rad;
    logic [ISB_W-1:0]        r6_sb;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (r_mode == MODE_ELLIPSE) begin
                r6_rad <= RAD_W'(r5_nx2) + RAD_W'(r5_ny2);
            end else begin
                r6_rad <= RAD_W'(r5_sb[VW-1:0]);
            end
            r6_sb <= {r5_alpha, r5_sb[DSB_W-1:DSB_W-2], r5_sb[DIVF_W-1:0]};
        end
    end

    // ---------------- distance root ----------------
    t_pipe_ctl               sq_ctl;
    logic                    sq_v;
    logic [RQ-1:0]           root;
    logic [ISB_W-1:0]        sq_sb;

    assign sq_ctl.en    = pipe_en;
    assign sq_ctl.valid = r6_v;

    fsam_isqrt #(
        .RAD_W (RAD_W),
        .SB_W  (ISB_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_rad   (r6_rad),
        .i_sb    (r6_sb),
        .o_valid (sq_v),
        .o_root  (root),
        .o_sb    (sq_sb)
    );

    // ---------------- stage 7: band decision per mode ----------------
    logic                    dec_one;
    logic                    dec_zero;
    logic [DIVF_W-1:0]       dec_num;
    logic                    r7_v;
    logic [DIVF_W-1:0]       r7_num;
    logic                    r7_one;
    logic                    r7_zero;
    logic [ALPHA_W-1:0]      r7_alpha;

    always_comb begin
        case (r_mode)
            MODE_RECT: begin
                dec_one  = (root == '0);
                dec_zero = DIVF_W'(root) > f_rect;
                dec_num  = DIVF_W'(root);
            end
            MODE_ELLIPSE: begin
                dec_one  = root <= RQ'(FACTOR_ONE);
                dec_zero = DIVF_W'(root) > (DIVF_W'(FACTOR_ONE) + f_ell);
                dec_num  = DIVF_W'(root - RQ'(FACTOR_ONE));
            end
            MODE_LINEAR: begin
                dec_one  = sq_sb[DIVF_W+1];
                dec_zero = sq_sb[DIVF_W];
                dec_num  = sq_sb[DIVF_W-1:0];
            end
            default: begin
                dec_one  = 1'b1;
                dec_zero = 1'b0;
                dec_num  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r7_num   <= (dec_one || dec_zero) ? '0 : dec_num;
            r7_one   <= dec_one;
            r7_zero  <= dec_zero;
            r7_alpha <= sq_sb[ISB_W-1:ISB_W-ALPHA_W];
        end
    end

    // ---------------- band fraction divider ----------------
    t_pipe_ctl               fd_ctl;
    logic                    fd_v;
    logic [FACTOR_W-1:0]     frac_q;
    logic [FSB_W-1:0]        fd_sb;

    assign fd_ctl.en    = pipe_en;
    assign fd_ctl.valid = r7_v;

    fsam_div #(
        .NUM_W (DIVF_W + FRAC_BITS),
        .DEN_W (DIVF_W),
        .QUO_W (FACTOR_W),
        .SB_W  (FSB_W)
    ) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fd_ctl),
        .i_num   ({r7_num, {FRAC_BITS{1'b0}}}),
        .i_den   (f_div),
        .i_sb    ({r7_alpha, r7_one, r7_zero}),
        .o_valid (fd_v),
        .o_quo   (frac_q),
        .o_sb    (fd_sb)
    );

    // ---------------- stage 8: factor and invert ----------------
    logic [FACTOR_W-1:0]     fac_raw;
    logic [FACTOR_W-1:0]     fac;
    logic                    r8_v;
    logic [FACTOR_W-1:0]     r8_fac;
    logic [ALPHA_W-1:0]      r8_alpha;

    always_comb begin
        if (fd_sb[1]) begin
            fac_raw = FACTOR_ONE;
        end else if (fd_sb[0]) begin
            fac_raw = '0;
        end else begin
            fac_raw = FACTOR_ONE - frac_q;
        end
        fac = (r_mode != MODE_NONE && r_invert) ? (FACTOR_ONE - fac_raw) : fac_raw;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r8_fac   <= fac;
            r8_alpha <= fd_sb[FSB_W-1:2];
        end
    end

    // ---------------- stage 9: alpha scaling ----------------
    logic [ALPHA_W+FACTOR_W-1:0] prod;
    logic [FACTOR_W+ALPHA_W-FRAC_BITS-1:0] prod_hi;
    logic                    r9_v;
    logic [ALPHA_W-1:0]      r9_alpha;
    logic [FACTOR_W-1:0]     r9_fac;

    assign prod    = (ALPHA_W+FACTOR_W)'(r8_alpha) * (ALPHA_W+FACTOR_W)'(r8_fac);
    assign prod_hi = prod[ALPHA_W+FACTOR_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r9_alpha <= (prod_hi > (ALPHA_W+FACTOR_W-FRAC_BITS)'({ALPHA_W{1'b1}}))
                        ? {ALPHA_W{1'b1}} : prod_hi[ALPHA_W-1:0];
            r9_fac   <= r8_fac;
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (pipe_en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= dn_v;
            r6_v <= r5_v;
            r7_v <= sq_v;
            r8_v <= fd_v;
            r9_v <= r8_v;
        end
    end

    // ---------------- output skid ----------------
    logic [ALPHA_W-1:0]      r_skid_alpha;
    logic [FACTOR_W-1:0]     r_skid_fac;
    logic [ALPHA_W-1:0]      out_alpha;
    logic [FACTOR_W-1:0]     out_fac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r9_v && !m_axis_tready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r9_v && !m_axis_tready) begin
            r_skid_alpha <= r9_alpha;
            r_skid_fac   <= r9_fac;
        end
    end

    assign out_alpha     = r_skid_v ? r_skid_alpha : r9_alpha;
    assign out_fac       = r_skid_v ? r_skid_fac : r9_fac;
    assign m_axis_tvalid = r_skid_v || r9_v;
    assign m_axis_tdata  = {{(OUT_TDATA_W-ALPHA_W-FACTOR_W){1'b0}}, out_fac, out_alpha};

    // ---------------- assertions ----------------
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !m_axis_tready |=> r_skid_v && $stable(r_skid_alpha) && $stable(r_skid_fac))
        else $error("skid item changed while stalled");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r9_v && !m_axis_tready))
        else $error("skid filled without a stalled result");

    a_last_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && r9_v |=> r9_v)
        else $error("item behind the skid was lost");

endmodule

`default_nettype wire
